// ===== design/recursive_crosstalk_canceller_unit_assert.svh =====
// Assertion macros shared by the crosstalk canceller RTL.
`ifndef RECURSIVE_CROSSTALK_CANCELLER_UNIT_ASSERT_SVH
`define RECURSIVE_CROSSTALK_CANCELLER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RCC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rcc_pkg.sv =====
`default_nettype none

package rcc_pkg;

    // Configuration register file
    localparam int CFG_IDX_BITS = 2;
    localparam int DLY_BITS     = 11;

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_TARGET_DELAY = t_cfg_idx'(0);
    localparam t_cfg_idx REG_ATTEN_GAIN   = t_cfg_idx'(1);

    // Enables for the two stages of the feedback gain path
    typedef struct packed {
        logic mul_en;   // delayed sample present, form the rounded product
        logic upd_en;   // product present, load the feedback register
    } t_stage_ctl;

endpackage

`default_nettype wire

// ===== design/recursive_crosstalk_canceller_unit.sv =====
// Recursive crosstalk canceller: each stereo request gives one result frame, each channel being
// its input plus the other channel's feedback, saturated. A new request is taken only once the
// feedback loop of the last one has run: delay line read, gain multiply, round and saturate
// into the feedback register, since the next request needs that feedback. Both delay lines
// share one memory of MAX_DELAY words, two samples wide. No clearing pass runs after reset:
// entries not yet written since reset read as zero, tracked through the write pointer and a
// wrap flag. A two-entry result queue lets requests keep coming while a result waits on the
// output. Write the configuration only while the block is idle; a new delay or gain applies
// from the next request on, and the delay lines and feedback are kept.
`default_nettype none

`include "recursive_crosstalk_canceller_unit_assert.svh"

module recursive_crosstalk_canceller_unit #(
    parameter int MAX_DELAY   = 1024,
    parameter int SAMPLE_BITS = 24,
    parameter int GAIN_BITS   = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [rcc_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [((GAIN_BITS > rcc_pkg::DLY_BITS) ? GAIN_BITS : rcc_pkg::DLY_BITS)-1:0]
                                                  i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]    i_sample_left,
    input  wire logic signed [SAMPLE_BITS-1:0]    i_sample_right,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic signed      [SAMPLE_BITS-1:0]    o_out_left,
    output logic signed      [SAMPLE_BITS-1:0]    o_out_right
);

    localparam int AW  = $clog2(MAX_DELAY);
    localparam int DW  = 2 * SAMPLE_BITS;
    localparam int DLB = rcc_pkg::DLY_BITS;

    localparam logic [AW-1:0]   LAST   = AW'(MAX_DELAY - 1);
    localparam logic [AW-1:0]   MAXA   = AW'(MAX_DELAY);
    localparam logic [31:0]     LAST32 = 32'(MAX_DELAY - 1);
    localparam logic signed [SAMPLE_BITS:0] SMAX = {2'b00, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS:0] SMIN = {2'b11, {(SAMPLE_BITS-1){1'b0}}};

    // Saturate a one-bit-grown sum to the sample range
    function automatic logic signed [SAMPLE_BITS-1:0] sat_sum(
        input logic signed [SAMPLE_BITS:0] v
    );
        logic signed [SAMPLE_BITS-1:0] res;
        if (v > SMAX) begin
            res = SMAX[SAMPLE_BITS-1:0];
        end else if (v < SMIN) begin
            res = SMIN[SAMPLE_BITS-1:0];
        end else begin
            res = v[SAMPLE_BITS-1:0];
        end
        return res;
    endfunction

    logic [DLB-1:0]       r_tdly;
    logic [GAIN_BITS-1:0] r_gain;
    logic [AW-1:0]        r_wp;
    logic                 r_full;
    logic                 r_vb;
    logic                 r_vc;
    logic                 r_hit;
    logic                 r_fwd;
    logic [DW-1:0]        r_fwd_data;

    logic                          w_acc;
    logic                          w_fifo_full;
    logic [DLB-1:0]                w_dm1;
    logic [AW-1:0]                 w_d;
    logic [AW-1:0]                 w_rp;
    logic signed [SAMPLE_BITS-1:0] w_feed_l;
    logic signed [SAMPLE_BITS-1:0] w_feed_r;
    logic signed [SAMPLE_BITS-1:0] w_sum_l;
    logic signed [SAMPLE_BITS-1:0] w_sum_r;
    logic [DW-1:0]                 w_wdata;
    logic [DW-1:0]                 w_rdata;
    logic [DW-1:0]                 w_line;
    logic [DW-1:0]                 w_q;
    rcc_pkg::t_stage_ctl           w_ctl;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tdly <= '0;
            r_gain <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rcc_pkg::REG_TARGET_DELAY: r_tdly <= i_cfg_data[DLB-1:0];
                rcc_pkg::REG_ATTEN_GAIN:   r_gain <= i_cfg_data[GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Effective delay: one sample less than the target, clamped to MAX_DELAY - 1
    assign w_dm1 = (r_tdly != '0) ? (r_tdly - DLB'(1)) : '0;

    always_comb begin
        if ({{(32-DLB){1'b0}}, w_dm1} > LAST32) begin
            w_d = LAST;
        end else begin
            w_d = AW'(w_dm1);
        end
    end

    assign w_rp = (r_wp >= w_d) ? (r_wp - w_d) : (r_wp - w_d + MAXA);

    // Input handshake: wait for the feedback loop and for queue room
    assign o_in_stall = r_vb || r_vc || w_fifo_full;
    assign w_acc      = i_in_valid && !o_in_stall;

    // Channel sums with cross feedback
    assign w_sum_l = sat_sum((SAMPLE_BITS+1)'(i_sample_left) + (SAMPLE_BITS+1)'(w_feed_r));
    assign w_sum_r = sat_sum((SAMPLE_BITS+1)'(i_sample_right) + (SAMPLE_BITS+1)'(w_feed_l));
    assign w_wdata = {w_sum_l, w_sum_r};

    rcc_line_mem #(
        .DEPTH (MAX_DELAY),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_acc),
        .i_waddr (r_wp),
        .i_wdata (w_wdata),
        .i_re    (w_acc),
        .i_raddr (w_rp),
        .o_rdata (w_rdata)
    );

    // Write pointer, wrap flag and stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_full <= 1'b0;
            r_vb   <= 1'b0;
            r_vc   <= 1'b0;
        end else begin
            r_vb <= w_acc;
            r_vc <= r_vb;
            if (w_acc) begin
                if (r_wp == LAST) begin
                    r_wp   <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_wp <= r_wp + AW'(1);
                end
            end
        end
    end

    // Read-side qualifiers: zero delay forwards the fresh sums, unwritten entries read zero
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_hit      <= r_full || (w_rp <= r_wp);
            r_fwd      <= (w_d == '0);
            r_fwd_data <= w_wdata;
        end
    end

    assign w_line = r_fwd ? r_fwd_data : (r_hit ? w_rdata : '0);

    assign w_ctl.mul_en = r_vb;
    assign w_ctl.upd_en = r_vc;

    rcc_gain #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .GAIN_BITS   (GAIN_BITS)
    ) u_gain_l (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_sample (w_line[DW-1 -: SAMPLE_BITS]),
        .i_gain   (r_gain),
        .o_feed   (w_feed_l)
    );

    rcc_gain #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .GAIN_BITS   (GAIN_BITS)
    ) u_gain_r (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_sample (w_line[SAMPLE_BITS-1:0]),
        .i_gain   (r_gain),
        .o_feed   (w_feed_r)
    );

    // Result queue
    rcc_out_fifo #(
        .DW (DW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_acc),
        .i_data  (w_wdata),
        .o_full  (w_fifo_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (w_q)
    );

    assign o_out_left  = w_q[DW-1 -: SAMPLE_BITS];
    assign o_out_right = w_q[SAMPLE_BITS-1:0];

    `RCC_ASSERT_SAME(a_accept_idle, i_clk, i_rst_n, w_acc, !r_vb && !r_vc, "request while busy")
    `RCC_ASSERT_NEXT(a_mul_then_upd, i_clk, i_rst_n, r_vb, r_vc && !r_vb, "stages out of step")
    `RCC_ASSERT_NEXT(a_upd_single, i_clk, i_rst_n, r_vc, !r_vc && !r_vb, "update repeated")
    `RCC_ASSERT_SAME(a_queue_room, i_clk, i_rst_n, w_acc, !w_fifo_full, "result queue overflow")

endmodule

`default_nettype wire

// ===== design/rcc_line_mem.sv =====
`default_nettype none

// Simple dual-port delay line storage, one write and one registered read.
module rcc_line_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 48
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write and read; a read of the address being written returns the old data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/rcc_gain.sv =====
`default_nettype none

// One feedback lane: product with the negated gain, rounding, saturation.
module rcc_gain #(
    parameter int SAMPLE_BITS = 24,
    parameter int GAIN_BITS   = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rcc_pkg::t_stage_ctl           i_ctl,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic        [GAIN_BITS-1:0]   i_gain,
    output logic signed      [SAMPLE_BITS-1:0] o_feed
);

    localparam int MW = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int PW = SAMPLE_BITS + GAIN_BITS + 2;

    localparam logic signed [PW-1:0] HALF = PW'(1) << (GAIN_BITS - 1);
    localparam logic signed [PW-1:0] SMAX = {{(GAIN_BITS+3){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [PW-1:0] SMIN = {{(GAIN_BITS+3){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [MW-1:0]          w_mul;
    logic signed [PW-1:0]          w_round;
    logic signed [PW-1:0]          w_shr;
    logic signed [SAMPLE_BITS-1:0] w_sat;
    logic signed [PW-1:0]          r_prod;
    logic signed [SAMPLE_BITS-1:0] r_feed;

    // Negated product plus half an LSB of the result
    assign w_mul   = i_sample * $signed({1'b0, i_gain});
    assign w_round = HALF - PW'(w_mul);

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= w_round;
        end
    end

    // Floor by arithmetic shift, then clamp to the sample range
    assign w_shr = r_prod >>> GAIN_BITS;

    always_comb begin
        if (w_shr > SMAX) begin
            w_sat = SMAX[SAMPLE_BITS-1:0];
        end else if (w_shr < SMIN) begin
            w_sat = SMIN[SAMPLE_BITS-1:0];
        end else begin
            w_sat = w_shr[SAMPLE_BITS-1:0];
        end
    end

    // Feedback register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feed <= '0;
        end else if (i_ctl.upd_en) begin
            r_feed <= w_sat;
        end
    end

    assign o_feed = r_feed;

endmodule

`default_nettype wire

// ===== design/rcc_out_fifo.sv =====
`default_nettype none

// Two-entry result queue between the datapath and the output channel.
module rcc_out_fifo #(
    parameter int DW = 48
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [DW-1:0] i_data,
    output logic               o_full,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic      [DW-1:0] o_data
);

    logic [DW-1:0] r_slot [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;
    logic          w_pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign w_pop   = o_valid && !i_stall;
    assign o_data  = r_slot[r_rd];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

    // Pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (w_pop) begin
                r_rd <= !r_rd;
            end
            if (i_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire
